### design/alle_pkg.sv
// package for the array linked list engine: sizes, codes, sequencer states
// no dependencies
`default_nettype none
package alle_pkg;
  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;
  localparam int LW         = $clog2(CAPACITY + 1);
  localparam int AW         = $clog2(CAPACITY);

  typedef enum logic [2:0] {
    REQ_INSERT = 3'd0, REQ_READ = 3'd1, REQ_REMOVE_AT = 3'd2,
    REQ_REMOVE_MATCH = 3'd3, REQ_REVERSE = 3'd4, REQ_CLEAR = 3'd5
  } req_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_RANGE = 3'd1, ST_FULL = 3'd2, ST_EMPTY = 3'd3, ST_NOTFOUND = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_POP_RD, S_POP_WAIT, S_WALK_RD, S_WALK_WAIT,
    S_INS_LINK, S_MATCH_WAIT, S_REM_FIX, S_REV_WAIT, S_DONE
  } state_t;

  localparam logic [LW-1:0] NULL_LINK = LW'(CAPACITY);
endpackage
`default_nettype wire

### design/alle_ram.sv
// generic single port write, single port registered read memory
// no dependencies
`default_nettype none
module alle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### design/array_linked_list_engine_unit.sv
// top level of the array linked list engine: sequencer over value and link memories
// depends on alle_pkg and alle_ram
//
// channel | direction | ports
// in      | input     | in_valid, in_stall, in_req_type, in_position, in_item_value
// out     | output    | out_valid, out_stall, out_read_value, out_status, out_count_now,
//         |           | out_is_empty, out_is_full
//
// a request passes dispatch, then an address step and a registered data step for every item
// visited, a free-stack pop where an insert reuses a freed slot, an unlink or relink where a
// remove needs one, and done; clear goes from dispatch straight to done.
// reset clears head, free stack, count and high-water mark; memories are not cleared.
// the block takes no request while one is in work; a result waiting in the output register
// only holds the sequencer in done when the next result is ready.
`default_nettype none
module array_linked_list_engine_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_req_type,
  input  wire logic [4:0]  in_position,
  input  wire logic [31:0] in_item_value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_read_value,
  output logic [2:0]       out_status,
  output logic [4:0]       out_count_now,
  output logic             out_is_empty,
  output logic             out_is_full
);
  localparam int LW = alle_pkg::LW;
  localparam int AW = alle_pkg::AW;
  localparam int DW = alle_pkg::DATA_WIDTH;

  alle_pkg::state_t state_r, state_nxt;

  logic [2:0]    req_r;
  logic [LW-1:0] pos_r, pos_nxt;
  logic [DW-1:0] val_r;
  logic [LW-1:0] head_r, head_nxt, free_r, free_nxt, cnt_r, cnt_nxt, mark_r, mark_nxt;
  logic [LW-1:0] slot_r, slot_nxt, prev_r, prev_nxt, cur_r, cur_nxt, idx_r, idx_nxt;
  logic [DW-1:0] rd_r, rd_nxt;
  logic [2:0]    st_r, st_nxt;
  logic          ov_r, ov_nxt;
  logic [DW-1:0] ord_r, ord_nxt;
  logic [2:0]    ost_r, ost_nxt;
  logic [LW-1:0] ocnt_r, ocnt_nxt;

  // memory ports
  logic          l_we, v_we;
  logic [AW-1:0] l_wa, l_ra, v_wa, v_ra;
  logic [LW-1:0] l_wd, l_rd;
  logic [DW-1:0] v_rd;

  alle_ram #(.WIDTH(LW), .DEPTH(alle_pkg::CAPACITY)) u_link (
    .clk(clk), .we(l_we), .waddr(l_wa), .wdata(l_wd), .raddr(l_ra), .rdata(l_rd));
  alle_ram #(.WIDTH(DW), .DEPTH(alle_pkg::CAPACITY)) u_val (
    .clk(clk), .we(v_we), .waddr(v_wa), .wdata(val_r), .raddr(v_ra), .rdata(v_rd));

  logic accept;
  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != alle_pkg::S_IDLE);

  logic [LW-1:0] cnt_dec;
  assign cnt_dec = cnt_r - LW'(1);

  // next state and datapath
  always_comb begin
    state_nxt = state_r;
    pos_nxt = pos_r; head_nxt = head_r; free_nxt = free_r; cnt_nxt = cnt_r;
    mark_nxt = mark_r; slot_nxt = slot_r; prev_nxt = prev_r; cur_nxt = cur_r;
    idx_nxt = idx_r; rd_nxt = rd_r; st_nxt = st_r; ov_nxt = ov_r;
    ord_nxt = ord_r; ost_nxt = ost_r; ocnt_nxt = ocnt_r;
    l_we = 1'b0; v_we = 1'b0;
    l_wa = cur_r[AW-1:0]; l_wd = prev_r; l_ra = cur_r[AW-1:0];
    v_wa = slot_r[AW-1:0]; v_ra = cur_r[AW-1:0];
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    case (state_r)
      alle_pkg::S_IDLE: begin
        if (accept) begin
          pos_nxt = LW'(in_position);
          state_nxt = alle_pkg::S_DISPATCH;
        end
      end
      alle_pkg::S_DISPATCH: begin
        rd_nxt = '0; st_nxt = alle_pkg::ST_OK;
        prev_nxt = alle_pkg::NULL_LINK; cur_nxt = head_r; idx_nxt = '0;
        state_nxt = alle_pkg::S_DONE;
        case (req_r)
          alle_pkg::REQ_INSERT: begin
            if (pos_r > cnt_r) st_nxt = alle_pkg::ST_RANGE;
            else if (cnt_r >= LW'(alle_pkg::CAPACITY)) st_nxt = alle_pkg::ST_FULL;
            else if (free_r != alle_pkg::NULL_LINK) begin
              slot_nxt = free_r; cur_nxt = free_r; state_nxt = alle_pkg::S_POP_RD;
            end else begin
              slot_nxt = mark_r; mark_nxt = mark_r + LW'(1);
              idx_nxt = LW'(1); state_nxt = alle_pkg::S_WALK_RD;
            end
          end
          alle_pkg::REQ_READ, alle_pkg::REQ_REMOVE_AT, alle_pkg::REQ_REMOVE_MATCH: begin
            if (cnt_r == '0) st_nxt = alle_pkg::ST_EMPTY;
            else if (req_r != alle_pkg::REQ_REMOVE_MATCH && pos_r >= cnt_r)
              st_nxt = alle_pkg::ST_RANGE;
            else state_nxt = alle_pkg::S_WALK_RD;
          end
          alle_pkg::REQ_REVERSE: if (cnt_r != '0) state_nxt = alle_pkg::S_WALK_RD;
          alle_pkg::REQ_CLEAR: begin
            cnt_nxt = '0; head_nxt = alle_pkg::NULL_LINK;
            free_nxt = alle_pkg::NULL_LINK; mark_nxt = '0;
          end
          default: ;
        endcase
      end
      // pop the free stack: read link of its top
      alle_pkg::S_POP_RD: state_nxt = alle_pkg::S_POP_WAIT;
      alle_pkg::S_POP_WAIT: begin
        free_nxt = l_rd; cur_nxt = head_r; idx_nxt = LW'(1);
        state_nxt = alle_pkg::S_WALK_RD;
      end
      // walk step: address cur presented, data next cycle
      alle_pkg::S_WALK_RD: begin
        if (req_r == alle_pkg::REQ_INSERT && pos_r == '0) begin
          l_we = 1'b1; l_wa = slot_r[AW-1:0]; l_wd = head_r;
          v_we = 1'b1; head_nxt = slot_r; cnt_nxt = cnt_r + LW'(1);
          state_nxt = alle_pkg::S_DONE;
        end else if (req_r == alle_pkg::REQ_REVERSE) state_nxt = alle_pkg::S_REV_WAIT;
        else if (req_r == alle_pkg::REQ_REMOVE_MATCH) state_nxt = alle_pkg::S_MATCH_WAIT;
        else if (req_r != alle_pkg::REQ_INSERT && idx_r == pos_r) begin
          state_nxt = alle_pkg::S_MATCH_WAIT;
        end else if (req_r == alle_pkg::REQ_INSERT && idx_r == pos_r) begin
          state_nxt = alle_pkg::S_WALK_WAIT;
        end else state_nxt = alle_pkg::S_WALK_WAIT;
      end
      alle_pkg::S_WALK_WAIT: begin
        if (req_r == alle_pkg::REQ_INSERT && idx_r == pos_r) begin
          // cur is predecessor; l_rd is its successor
          l_we = 1'b1; l_wa = slot_r[AW-1:0]; l_wd = l_rd;
          v_we = 1'b1; state_nxt = alle_pkg::S_INS_LINK;
        end else begin
          prev_nxt = cur_r; cur_nxt = l_rd; idx_nxt = idx_r + LW'(1);
          state_nxt = alle_pkg::S_WALK_RD;
        end
      end
      alle_pkg::S_INS_LINK: begin
        l_we = 1'b1; l_wa = cur_r[AW-1:0]; l_wd = slot_r;
        cnt_nxt = cnt_r + LW'(1); state_nxt = alle_pkg::S_DONE;
      end
      // value and link of cur available
      alle_pkg::S_MATCH_WAIT: begin
        if (req_r == alle_pkg::REQ_READ) begin
          rd_nxt = v_rd; state_nxt = alle_pkg::S_DONE;
        end else if (req_r == alle_pkg::REQ_REMOVE_AT || v_rd == val_r) begin
          rd_nxt = v_rd; slot_nxt = l_rd; state_nxt = alle_pkg::S_REM_FIX;
        end else if (idx_r + LW'(1) >= cnt_r) begin
          st_nxt = alle_pkg::ST_NOTFOUND; state_nxt = alle_pkg::S_DONE;
        end else begin
          prev_nxt = cur_r; cur_nxt = l_rd; idx_nxt = idx_r + LW'(1);
          state_nxt = alle_pkg::S_WALK_RD;
        end
      end
      // unlink cur (successor in slot_r), push onto free stack unless the list becomes empty
      alle_pkg::S_REM_FIX: begin
        cnt_nxt = cnt_dec;
        if (cnt_dec == '0) begin
          head_nxt = alle_pkg::NULL_LINK; free_nxt = alle_pkg::NULL_LINK; mark_nxt = '0;
        end else begin
          l_we = 1'b1; l_wa = cur_r[AW-1:0]; l_wd = free_r; free_nxt = cur_r;
          if (prev_r == alle_pkg::NULL_LINK) head_nxt = slot_r;
          else state_nxt = alle_pkg::S_INS_LINK;
        end
        if (state_nxt == alle_pkg::S_REM_FIX) state_nxt = alle_pkg::S_DONE;
        if (prev_r != alle_pkg::NULL_LINK && cnt_dec != '0) begin
          // reuse link write path: cur_r <= prev, slot_r stays successor
          cur_nxt = prev_r; cnt_nxt = cnt_dec - LW'(1);
        end
      end
      alle_pkg::S_REV_WAIT: begin
        l_we = 1'b1; l_wa = cur_r[AW-1:0]; l_wd = prev_r;
        prev_nxt = cur_r; cur_nxt = l_rd; idx_nxt = idx_r + LW'(1);
        if (idx_r + LW'(1) == cnt_r) begin
          head_nxt = cur_r; state_nxt = alle_pkg::S_DONE;
        end else state_nxt = alle_pkg::S_WALK_RD;
      end
      // hand the result to the output register once it is free
      alle_pkg::S_DONE: begin
        if (!ov_r || !out_stall) begin
          ord_nxt = rd_r; ost_nxt = st_r; ocnt_nxt = cnt_r;
          ov_nxt = 1'b1; state_nxt = alle_pkg::S_IDLE;
        end
      end
      default: state_nxt = alle_pkg::S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= alle_pkg::S_IDLE;
      head_r  <= alle_pkg::NULL_LINK;
      free_r  <= alle_pkg::NULL_LINK;
      cnt_r   <= '0;
      mark_r  <= '0;
      ov_r    <= 1'b0;
      ocnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      free_r  <= free_nxt;
      cnt_r   <= cnt_nxt;
      mark_r  <= mark_nxt;
      ov_r    <= ov_nxt;
      ocnt_r  <= ocnt_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_req_type;
      val_r <= in_item_value;
    end
    pos_r <= pos_nxt; slot_r <= slot_nxt; prev_r <= prev_nxt; cur_r <= cur_nxt;
    idx_r <= idx_nxt; rd_r <= rd_nxt; st_r <= st_nxt;
    ord_r <= ord_nxt; ost_r <= ost_nxt;
  end

  // result outputs
  assign out_valid      = ov_r;
  assign out_read_value = ord_r;
  assign out_status     = ost_r;
  assign out_count_now  = 5'(ocnt_r);
  assign out_is_empty   = (ocnt_r == '0);
  assign out_is_full    = (ocnt_r == LW'(alle_pkg::CAPACITY));
endmodule
`default_nettype wire

### test/tb_array_linked_list_engine_unit.sv
// regression bench for the array linked list engine: directed and random requests
// depends on alle_pkg and array_linked_list_engine_unit
`default_nettype none
module tb_array_linked_list_engine_unit;

  localparam int WATCH_LIMIT = 20000;

  typedef struct packed {
    logic [31:0] read_value;
    logic [2:0]  status;
    logic [4:0]  count_now;
    logic        is_empty;
    logic        is_full;
  } reply_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_req_type = '0;
  logic [4:0]  in_position = '0;
  logic [31:0] in_item_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_read_value;
  logic [2:0]  out_status;
  logic [4:0]  out_count_now;
  logic        out_is_empty;
  logic        out_is_full;

  // shadow copy of the list, one spare entry for the null link
  logic [31:0] mdl_val [alle_pkg::CAPACITY + 1];
  logic [4:0]  mdl_link [alle_pkg::CAPACITY + 1];
  logic [4:0]  mdl_head, mdl_free, mdl_count, mdl_fresh;

  reply_t replies_due[$];
  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;
  int     idle_count = 0;
  bit     failed = 1'b0;

  array_linked_list_engine_unit dut (.*);

  always #5 clk = ~clk;

  // walk from head to the slot before position pos (pos >= 1)
  function automatic logic [4:0] slot_before(input logic [4:0] pos);
    logic [4:0] s;
    s = mdl_head;
    for (int i = 1; i < pos; i++) s = mdl_link[s];
    return s;
  endfunction

  // take slot s out of the list and push it on the free stack
  function automatic void unlink_slot(input logic [4:0] prev, input logic [4:0] s);
    if (prev == alle_pkg::NULL_LINK) mdl_head = mdl_link[s];
    else mdl_link[prev] = mdl_link[s];
    mdl_count--;
    mdl_link[s] = mdl_free;
    mdl_free = s;
    if (mdl_count == 0) begin
      mdl_free = alle_pkg::NULL_LINK;
      mdl_fresh = 0;
      mdl_head = alle_pkg::NULL_LINK;
    end
  endfunction

  // compute the reply for one request and update the shadow list
  function automatic reply_t list_reply(input logic [2:0] req, input logic [4:0] pos,
                                        input logic [31:0] val);
    reply_t r;
    logic [4:0] slot, prev, cur, nx;
    bit found;
    r = '0;
    r.status = alle_pkg::ST_OK;
    case (req)
      alle_pkg::REQ_INSERT: begin
        if (pos > mdl_count) r.status = alle_pkg::ST_RANGE;
        else if (mdl_count >= alle_pkg::CAPACITY) r.status = alle_pkg::ST_FULL;
        else begin
          if (mdl_free != alle_pkg::NULL_LINK) begin
            slot = mdl_free;
            mdl_free = mdl_link[slot];
          end else begin
            slot = mdl_fresh;
            mdl_fresh++;
          end
          if (pos == 0) begin
            mdl_link[slot] = mdl_head;
            mdl_head = slot;
          end else begin
            prev = slot_before(pos);
            mdl_link[slot] = mdl_link[prev];
            mdl_link[prev] = slot;
          end
          mdl_val[slot] = val;
          mdl_count++;
        end
      end
      alle_pkg::REQ_READ, alle_pkg::REQ_REMOVE_AT: begin
        if (mdl_count == 0) r.status = alle_pkg::ST_EMPTY;
        else if (pos >= mdl_count) r.status = alle_pkg::ST_RANGE;
        else begin
          prev = (pos == 0) ? alle_pkg::NULL_LINK : slot_before(pos);
          cur = (prev == alle_pkg::NULL_LINK) ? mdl_head : mdl_link[prev];
          r.read_value = mdl_val[cur];
          if (req == alle_pkg::REQ_REMOVE_AT) unlink_slot(prev, cur);
        end
      end
      alle_pkg::REQ_REMOVE_MATCH: begin
        if (mdl_count == 0) r.status = alle_pkg::ST_EMPTY;
        else begin
          prev = alle_pkg::NULL_LINK;
          cur = mdl_head;
          found = 0;
          for (int i = 0; i < mdl_count; i++) begin
            if (mdl_val[cur] == val) begin
              found = 1;
              break;
            end
            prev = cur;
            cur = mdl_link[cur];
          end
          if (found) begin
            r.read_value = mdl_val[cur];
            unlink_slot(prev, cur);
          end else r.status = alle_pkg::ST_NOTFOUND;
        end
      end
      alle_pkg::REQ_REVERSE: begin
        prev = alle_pkg::NULL_LINK;
        cur = mdl_head;
        for (int i = 0; i < mdl_count; i++) begin
          nx = mdl_link[cur];
          mdl_link[cur] = prev;
          prev = cur;
          cur = nx;
        end
        if (mdl_count != 0) mdl_head = prev;
      end
      alle_pkg::REQ_CLEAR: begin
        mdl_count = 0;
        mdl_head = alle_pkg::NULL_LINK;
        mdl_free = alle_pkg::NULL_LINK;
        mdl_fresh = 0;
      end
      default: ;
    endcase
    r.count_now = mdl_count;
    r.is_empty = (mdl_count == 0);
    r.is_full = (mdl_count == alle_pkg::CAPACITY);
    return r;
  endfunction

  // one request transfer, with random sender gaps
  task automatic send_req(input logic [2:0] req, input logic [4:0] pos,
                          input logic [31:0] val);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    in_valid <= 1'b1;
    in_req_type <= req;
    in_position <= pos;
    in_item_value <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    replies_due.push_back(list_reply(req, pos, val));
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_replies();
    while (replies_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // random values biased toward ones already in the list
  function automatic logic [31:0] pick_value();
    if (mdl_count != 0 && $urandom_range(1)) begin
      logic [4:0] s;
      s = mdl_head;
      for (int i = $urandom_range(mdl_count - 1); i > 0; i--) s = mdl_link[s];
      return mdl_val[s];
    end
    return $urandom_range(3) == 0 ? $urandom_range(7) : $urandom;
  endfunction

  // receiver stall and result check
  always @(posedge clk) begin
    reply_t e;
    if (rst_n) begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
      if (out_valid && !out_stall) begin
        if (replies_due.size() == 0) begin
          $error("unexpected result transfer");
          failed = 1'b1;
        end else begin
          e = replies_due.pop_front();
          if (out_read_value !== e.read_value) begin
            $error("read_value exp %h got %h", e.read_value, out_read_value);
            failed = 1'b1;
          end
          if (out_status !== e.status) begin
            $error("status exp %0d got %0d", e.status, out_status);
            failed = 1'b1;
          end
          if (out_count_now !== e.count_now) begin
            $error("count_now exp %0d got %0d", e.count_now, out_count_now);
            failed = 1'b1;
          end
          if (out_is_empty !== e.is_empty) begin
            $error("is_empty exp %0d got %0d", e.is_empty, out_is_empty);
            failed = 1'b1;
          end
          if (out_is_full !== e.is_full) begin
            $error("is_full exp %0d got %0d", e.is_full, out_is_full);
            failed = 1'b1;
          end
        end
      end
    end
  end

  // watchdog on cycles with no transfer
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_count <= 0;
    else idle_count <= idle_count + 1;
    if (idle_count >= WATCH_LIMIT) begin
      $display("array_linked_list_engine_unit regression: fail");
      $finish;
    end
  end

  // edge cases: empty list, range errors, fill to full, unused codes
  task automatic test_directed();
    send_req(alle_pkg::REQ_READ, 0, 0);
    send_req(alle_pkg::REQ_REMOVE_AT, 0, 0);
    send_req(alle_pkg::REQ_REMOVE_MATCH, 0, 32'hFFFF_FFFF);
    send_req(alle_pkg::REQ_REVERSE, 0, 0);
    send_req(alle_pkg::REQ_CLEAR, 0, 0);
    send_req(alle_pkg::REQ_INSERT, 5'd31, 32'h1);
    send_req(3'd6, 5'd31, 32'hFFFF_FFFF);
    send_req(3'd7, 0, 0);
    for (int i = 0; i < alle_pkg::CAPACITY; i++)
      send_req(alle_pkg::REQ_INSERT, (i % 2) ? 5'(i) : 5'd0,
               (i == 3) ? 32'hFFFF_FFFF : 32'(i));
    send_req(alle_pkg::REQ_INSERT, 0, 32'h55);
    send_req(alle_pkg::REQ_INSERT, 5'd17, 32'h55);
    send_req(alle_pkg::REQ_READ, 5'd15, 0);
    send_req(alle_pkg::REQ_READ, 5'd16, 0);
    send_req(alle_pkg::REQ_REVERSE, 0, 0);
  endtask

  // well-formed list traffic with some noise
  task automatic test_random(input int n);
    logic [2:0] req;
    logic [4:0] pos;
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < 35) req = alle_pkg::REQ_INSERT;
      else if (k < 55) req = alle_pkg::REQ_READ;
      else if (k < 70) req = alle_pkg::REQ_REMOVE_AT;
      else if (k < 85) req = alle_pkg::REQ_REMOVE_MATCH;
      else if (k < 93) req = alle_pkg::REQ_REVERSE;
      else if (k < 97) req = alle_pkg::REQ_CLEAR;
      else req = 3'($urandom_range(7));
      if ($urandom_range(9) == 0) pos = 5'($urandom_range(31));
      else pos = 5'($urandom_range(mdl_count));
      send_req(req, pos, pick_value());
    end
  endtask

  // pause the sender until every reply is back
  task automatic test_hold_off();
    drain_replies();
    send_req(alle_pkg::REQ_READ, 0, 0);
    drain_replies();
  endtask

  initial begin
    mdl_head = alle_pkg::NULL_LINK;
    mdl_free = alle_pkg::NULL_LINK;
    mdl_count = 0;
    mdl_fresh = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(100);
    send_idle_pct = 63;
    test_random(100);
    send_idle_pct = 0;
    recv_stall_pct = 63;
    test_random(100);
    test_hold_off();
    send_idle_pct = 19;
    recv_stall_pct = 19;
    test_random(100);
    recv_stall_pct = 0;
    drain_replies();
    if (!failed) $display("array_linked_list_engine_unit regression: pass");
    else $display("array_linked_list_engine_unit regression: fail");
    $finish;
  end
endmodule
`default_nettype wire

### files.f
design/alle_pkg.sv
design/alle_ram.sv
design/array_linked_list_engine_unit.sv
test/tb_array_linked_list_engine_unit.sv
